// ----- sv/sbfp_pkg.sv -----
// Package for the serial block frame parser: configuration and result types,
// register indexes, reset values and status codes. No dependencies.
`default_nettype none

package sbfp_pkg;

	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRAILER = 2'd3;

	// Register reset values
	localparam logic [7:0] HEADER_RST  = 8'h55;
	localparam logic [7:0] SYNC_RST    = 8'h3C;
	localparam logic [7:0] TYPE_RST    = 8'h01;
	localparam logic [7:0] TRAILER_RST = 8'h55;

	// Result kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Frame end status codes; checksum and trailer bits combine
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SUM_BAD  = 3'd1;
	localparam logic [2:0] ST_TRL_BAD  = 3'd2;
	localparam logic [2:0] ST_TYPE_ERR = 3'd4;

	typedef struct packed {
		logic [7:0] header_value;
		logic [7:0] sync_value;
		logic [7:0] accepted_type;
		logic [7:0] trailer_value;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [15:0] frame_length;
		logic [2:0]  status;
	} res_t;

endpackage

`default_nettype wire

// ----- sv/sbfp_if.sv -----
// Valid/ready channel interfaces of the frame parser: received bytes in,
// parse results out. Uses no package.
`default_nettype none

interface sbfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sbfp_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic [15:0] byte_index;
	logic [15:0] frame_length;
	logic [2:0]  status;

	modport source (output valid, output kind, output data_byte, output byte_index,
		output frame_length, output status, input ready);
	modport sink (input valid, input kind, input data_byte, input byte_index,
		input frame_length, input status, output ready);
endinterface

`default_nettype wire

// ----- sv/sbfp_parse_core.sv -----
// Frame parsing state machine: takes one byte per step and forms the result.
// Depends on sbfp_pkg.
`default_nettype none

module sbfp_parse_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    rx_byte,
	input  wire sbfp_pkg::cfg_t cfg,
	output logic               has_res,
	output sbfp_pkg::res_t     res
);

	typedef enum logic [2:0] {
		PH_HUNT, PH_SYNC, PH_TYPE, PH_LENLO, PH_LENHI, PH_DATA, PH_CSUM, PH_TRAIL
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic        mism_q, mism_d;
	logic [15:0] count_inc;
	logic [15:0] len_full;

	assign count_inc = count_q + 16'd1;
	assign len_full  = {rx_byte, len_q[7:0]};

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		count_d = count_q;
		sum_d   = sum_q;
		mism_d  = mism_q;
		has_res = 1'b0;
		res     = '0;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == cfg.header_value) phase_d = PH_SYNC;
			end
			PH_SYNC: begin
				if (rx_byte == cfg.sync_value) phase_d = PH_TYPE;
			end
			PH_TYPE: begin
				if (rx_byte == cfg.accepted_type) begin
					phase_d = PH_LENLO;
				end else begin
					has_res    = 1'b1;
					res.kind   = sbfp_pkg::KIND_END;
					res.status = sbfp_pkg::ST_TYPE_ERR;
					phase_d    = PH_HUNT;
				end
			end
			PH_LENLO: begin
				len_d   = {8'd0, rx_byte};
				phase_d = PH_LENHI;
			end
			PH_LENHI: begin
				len_d   = len_full;
				count_d = '0;
				sum_d   = '0;
				mism_d  = 1'b0;
				phase_d = (len_full == 16'd0) ? PH_CSUM : PH_DATA;
			end
			PH_DATA: begin
				has_res        = 1'b1;
				res.kind       = sbfp_pkg::KIND_DATA;
				res.data_byte  = rx_byte;
				res.byte_index = count_q;
				sum_d          = sum_q + rx_byte;
				count_d        = count_inc;
				if (count_inc == len_q) phase_d = PH_CSUM;
			end
			PH_CSUM: begin
				mism_d  = (rx_byte != sum_q);
				phase_d = PH_TRAIL;
			end
			PH_TRAIL: begin
				has_res          = 1'b1;
				res.kind         = sbfp_pkg::KIND_END;
				res.frame_length = len_q;
				res.status       = (mism_q ? sbfp_pkg::ST_SUM_BAD : sbfp_pkg::ST_OK)
					| ((rx_byte != cfg.trailer_value) ? sbfp_pkg::ST_TRL_BAD : sbfp_pkg::ST_OK);
				phase_d          = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
			mism_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			mism_q  <= mism_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/serial_block_frame_parser.sv -----
// Serial block frame parser top level: input register, parse core, result
// register and configuration registers. Depends on sbfp_pkg, sbfp_if.sv and
// sbfp_parse_core.
//
// Use: received bytes enter on rx (valid/ready), one item per byte. Each
// payload byte of an accepted frame gives a data item on result with its
// index; the trailer gives a frame end item with the declared length and the
// status (ok, checksum bad, trailer bad, or both); a wrong type byte gives a
// type error end item. Header, sync and other bytes give no item.
// A byte accepted into the input register is parsed from there into the result
// register, and its item is then offered on result.
// Throughput: one byte per cycle unless an item waits on a held result, set
// by the single parse step between the input register and the result register.
// Stall: while result is held, bytes that give no item still drain; a byte
// that gives an item waits in the input register, and rx drops ready only
// when that register is also full.
// Reset: the parser returns to header hunt and the registers take their
// default values (header 0x55, sync 0x3C, type 0x01, trailer 0x55).
// Configuration: cfg_we writes cfg_data to register cfg_index at once.
`default_nettype none

module serial_block_frame_parser (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [sbfp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [7:0]                          cfg_data,
	sbfp_in_if.sink                                  rx,
	sbfp_out_if.source                               result
);

	sbfp_pkg::cfg_t cfg_q;
	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           out_valid_q;
	sbfp_pkg::res_t res_q;
	sbfp_pkg::res_t core_res;
	logic           core_has_res;
	logic           out_free;
	logic           advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_value  <= sbfp_pkg::HEADER_RST;
			cfg_q.sync_value    <= sbfp_pkg::SYNC_RST;
			cfg_q.accepted_type <= sbfp_pkg::TYPE_RST;
			cfg_q.trailer_value <= sbfp_pkg::TRAILER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sbfp_pkg::REG_HEADER:  cfg_q.header_value  <= cfg_data;
				sbfp_pkg::REG_SYNC:    cfg_q.sync_value    <= cfg_data;
				sbfp_pkg::REG_TYPE:    cfg_q.accepted_type <= cfg_data;
				sbfp_pkg::REG_TRAILER: cfg_q.trailer_value <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the held byte when its item, if any, has room
	assign out_free = !out_valid_q || result.ready;
	assign advance  = valid_s1 && (out_free || !core_has_res);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) byte_s1 <= rx.rx_byte;
	end

	sbfp_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.has_res (core_has_res),
		.res     (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && core_has_res) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_has_res) res_q <= core_res;
	end

	assign result.valid        = out_valid_q;
	assign result.kind         = res_q.kind;
	assign result.data_byte    = res_q.data_byte;
	assign result.byte_index   = res_q.byte_index;
	assign result.frame_length = res_q.frame_length;
	assign result.status       = res_q.status;

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> rx.ready)
		else $error("input stage empty but rx not ready");

	a_data_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.kind == sbfp_pkg::KIND_DATA)
		|-> (res_q.status == sbfp_pkg::ST_OK && res_q.frame_length == 16'd0))
		else $error("data item carries end fields");

	a_type_err_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status == sbfp_pkg::ST_TYPE_ERR)
		|-> (res_q.kind == sbfp_pkg::KIND_END && res_q.frame_length == 16'd0
			&& res_q.byte_index == 16'd0))
		else $error("type error item malformed");

	a_no_drop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !(advance && core_has_res))
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire
